>>> design/pldm_pkg.sv
// Shared types and constants for the piecewise-linear dimming map.
// No dependencies; imported by every design file of the block.
`default_nettype none

package pldm_pkg;

    localparam int BREAKPOINTS = 4;
    localparam int SEGMENTS    = BREAKPOINTS - 1;
    localparam int PT_W        = $clog2(BREAKPOINTS);

    localparam int REQ_W     = 16;
    localparam int LEVEL_W   = 10;
    localparam int DUTY_W    = 16;
    localparam int PROD_W    = LEVEL_W + DUTY_W;
    localparam int CNT_W     = $clog2(PROD_W);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int LEVEL_MAX = 1000;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY0  = 3'd4;

    localparam logic [3:0][LEVEL_W-1:0] LEVEL_RST = {10'd1000, 10'd500, 10'd250, 10'd0};
    localparam logic [3:0][DUTY_W-1:0]  DUTY_RST  = {16'd65535, 16'd16000, 16'd4000, 16'd0};

    typedef logic [BREAKPOINTS-1:0][LEVEL_W-1:0] level_arr_t;
    typedef logic [BREAKPOINTS-1:0][DUTY_W-1:0]  duty_arr_t;

    typedef struct packed {
        logic start;
        logic [PROD_W-1:0] dividend;
        logic [LEVEL_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> design/pldm_cfg.sv
// Breakpoint register file: level and duty per point, written by index.
// Depends on pldm_pkg.
`default_nettype none

module pldm_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [pldm_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [pldm_pkg::CFG_DATA_W-1:0] wr_data,
    output pldm_pkg::level_arr_t                levels,
    output pldm_pkg::duty_arr_t                 duties
);
    import pldm_pkg::*;

    level_arr_t level_reg;
    duty_arr_t  duty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < BREAKPOINTS; i++)
            begin
                level_reg[i] <= LEVEL_RST[i];
                duty_reg[i]  <= DUTY_RST[i];
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < BREAKPOINTS; i++)
            begin
                if (wr_index == CFG_IDX_W'(REG_LEVEL0 + i))
                    level_reg[i] <= wr_data[LEVEL_W-1:0];
                if (wr_index == CFG_IDX_W'(REG_DUTY0 + i))
                    duty_reg[i] <= wr_data[DUTY_W-1:0];
            end
        end
    end

    assign levels = level_reg;
    assign duties = duty_reg;

endmodule

`default_nettype wire

>>> design/pldm_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on pldm_pkg.
`default_nettype none

module pldm_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  pldm_pkg::div_req_t                req,
    output pldm_pkg::div_stat_t               stat,
    output logic [pldm_pkg::PROD_W-1:0]       quotient
);
    import pldm_pkg::*;

    logic                busy_reg,  busy_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [PROD_W-1:0]   dq_reg,    dq_next;
    logic [LEVEL_W-1:0]  rem_reg,   rem_next;
    logic [LEVEL_W-1:0]  den_reg,   den_next;
    logic [LEVEL_W:0]    trial;
    logic [LEVEL_W:0]    diff;
    logic                fits;

    assign trial = {rem_reg, dq_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(PROD_W - 1);
            dq_next   = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[PROD_W-2:0], fits};
            rem_next = fits ? diff[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);
    assign quotient  = dq_reg;

endmodule

`default_nettype wire

>>> design/piecewise_linear_dimming_map_core.sv
// Top level of the piecewise-linear dimming map: sequencer, segment search, multiply and
// output register around the divider. Depends on pldm_pkg, pldm_cfg, pldm_div.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-------------------------------
//   in       | in_valid / in_ready  | requested_level
//   out      | out_valid / out_ready| duty_value, map_error
//   cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A request passes an accept step, a search one segment at a time, a multiply step, the
// bit-serial divider and a load into the output register.
// A repeated request gives no result; uncovered levels and zero-width hits skip the divider.
// in_ready is high only while the sequencer is idle; a waiting result stalls only the load.
// Reset clears the breakpoints to their defaults and forgets the last request.
`default_nettype none

module piecewise_linear_dimming_map_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic signed [pldm_pkg::REQ_W-1:0] requested_level,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [pldm_pkg::DUTY_W-1:0]          duty_value,
    output logic                                 map_error,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [pldm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pldm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import pldm_pkg::*;

    state_t              state_reg, state_next;
    logic                last_valid_reg, last_valid_next;
    logic [REQ_W-1:0]    last_req_reg,   last_req_next;
    logic [LEVEL_W-1:0]  x_reg,          x_next;
    logic [PT_W-1:0]     seg_reg,        seg_next;
    logic                err_reg,        err_next;
    logic                neg_reg,        neg_next;
    logic [DUTY_W-1:0]   base_reg,       base_next;
    logic                out_valid_reg,  out_valid_next;
    logic [DUTY_W-1:0]   duty_reg,       duty_next;
    logic                err_out_reg,    err_out_next;

    level_arr_t          levels;
    duty_arr_t           duties;
    div_req_t            div_req;
    div_stat_t           div_stat;
    logic [PROD_W-1:0]   quotient;

    logic                in_accept;
    logic                dup;
    logic [LEVEL_W-1:0]  x_clamped;
    logic [PT_W-1:0]     seg_hi;
    logic [LEVEL_W-1:0]  lo_lvl, hi_lvl;
    logic [DUTY_W-1:0]   lo_duty, hi_duty;
    logic                hit, zero_width, last_seg;
    logic [DUTY_W:0]     dd;
    logic [DUTY_W-1:0]   dd_mag;
    logic [LEVEL_W-1:0]  dx;
    logic [DUTY_W-1:0]   q16;
    logic                slot_free;

    pldm_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .levels   (levels),
        .duties   (duties)
    );

    pldm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (quotient)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign dup       = last_valid_reg && (requested_level == last_req_reg);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (requested_level[REQ_W-1])
            x_clamped = '0;
        else if (requested_level > REQ_W'(LEVEL_MAX))
            x_clamped = LEVEL_W'(LEVEL_MAX);
        else
            x_clamped = requested_level[LEVEL_W-1:0];
    end

    assign seg_hi     = PT_W'(seg_reg + 1'b1);
    assign lo_lvl     = levels[seg_reg];
    assign hi_lvl     = levels[seg_hi];
    assign lo_duty    = duties[seg_reg];
    assign hi_duty    = duties[seg_hi];
    assign hit        = (lo_lvl <= x_reg) && (x_reg <= hi_lvl);
    assign zero_width = (lo_lvl == hi_lvl);
    assign last_seg   = (seg_reg == PT_W'(SEGMENTS - 1));

    assign dd     = {1'b0, hi_duty} - {1'b0, lo_duty};
    assign dd_mag = dd[DUTY_W] ? DUTY_W'(-dd) : dd[DUTY_W-1:0];
    assign dx     = x_reg - lo_lvl;
    assign q16    = quotient[DUTY_W-1:0];

    assign div_req.start    = (state_reg == ST_MUL);
    assign div_req.dividend = PROD_W'(dx) * PROD_W'(dd_mag);
    assign div_req.divisor  = hi_lvl - lo_lvl;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_accept && !dup)
                    state_next = ST_SEARCH;
            ST_SEARCH:
                if (hit)
                    state_next = zero_width ? ST_DONE : ST_MUL;
                else if (last_seg)
                    state_next = ST_DONE;
            ST_MUL:
                state_next = ST_DIV;
            ST_DIV:
                if (div_stat.done)
                    state_next = ST_DONE;
            ST_DONE:
                if (slot_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        last_valid_next = last_valid_reg;
        last_req_next   = last_req_reg;
        x_next          = x_reg;
        seg_next        = seg_reg;
        err_next        = err_reg;
        neg_next        = neg_reg;
        base_next       = base_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        duty_next       = duty_reg;
        err_out_next    = err_out_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_accept && !dup)
                begin
                    last_valid_next = 1'b1;
                    last_req_next   = requested_level;
                    x_next          = x_clamped;
                    seg_next        = '0;
                    err_next        = 1'b1;
                end
            ST_SEARCH:
                if (!hit && !last_seg)
                    seg_next = seg_hi;
            ST_MUL:
            begin
                err_next  = 1'b0;
                neg_next  = dd[DUTY_W];
                base_next = lo_duty;
            end
            ST_DIV:
            begin
            end
            ST_DONE:
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    err_out_next   = err_reg;
                    if (err_reg)
                        duty_next = '0;
                    else
                        duty_next = neg_reg ? base_reg - q16 : base_reg + q16;
                end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_valid_reg <= last_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_req_reg <= last_req_next;
        x_reg        <= x_next;
        seg_reg      <= seg_next;
        err_reg      <= err_next;
        neg_reg      <= neg_next;
        base_reg     <= base_next;
        duty_reg     <= duty_next;
        err_out_reg  <= err_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign duty_value = duty_reg;
    assign map_error  = err_out_reg;

endmodule

`default_nettype wire

>>> design/pldm_chk.sv
// Port-level checker for the dimming map core, attached by bind.
// Depends on pldm_pkg and piecewise_linear_dimming_map_core.
`default_nettype none

module pldm_chk (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [pldm_pkg::DUTY_W-1:0]       duty_value,
    input wire logic                              map_error
);
    import pldm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && map_error |-> duty_value == '0)
        else $error("error result with nonzero duty");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result one cycle after request");

    a_busy_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result loaded while idle");

endmodule

bind piecewise_linear_dimming_map_core pldm_chk u_pldm_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .duty_value (duty_value),
    .map_error  (map_error)
);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for piecewise_linear_dimming_map_core: directed table, then
// phased random requests under changing breakpoint tables, checked by a local interpolator.
// Depends on pldm_pkg and the RTL of the block; reads no files.
module tb;
    import pldm_pkg::*;

    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 200;
    localparam int GAP_PCT      = 32;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              err;
    } dim_result_t;

    typedef enum bit {ROW_REQUEST, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_IDX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]   data;
        logic signed [REQ_W-1:0] req;
        bit                      known;
        dim_result_t             typed;
    } stim_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic signed [REQ_W-1:0] requested_level = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [DUTY_W-1:0]       duty_value;
    logic                    map_error;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    stim_row_t   directed_q[$];
    dim_result_t expected_duty_q[$];

    logic [LEVEL_W-1:0]      seg_level [BREAKPOINTS];
    logic [DUTY_W-1:0]       seg_duty  [BREAKPOINTS];
    logic signed [REQ_W-1:0] last_level = '0;
    bit                      last_seen = 1'b0;

    bit steady = 1'b0;
    int hold_epoch = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatch_count = 0;

    int phase, produced, pick, k, i, a, b;
    int lv [BREAKPOINTS];
    int dt [BREAKPOINTS];
    logic signed [REQ_W-1:0] v;

    piecewise_linear_dimming_map_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .requested_level (requested_level),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .duty_value      (duty_value),
        .map_error       (map_error),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic dim_result_t map_level(logic signed [REQ_W-1:0] req);
        dim_result_t r;
        int x;
        int lo_in, hi_in, lo_out, hi_out;
        bit found;
        r.duty = '0;
        r.err  = 1'b1;
        found  = 1'b0;
        x = req;
        if (x < 0)
            x = 0;
        if (x > LEVEL_MAX)
            x = LEVEL_MAX;
        for (int s = 0; s < BREAKPOINTS - 1; s++)
        begin
            lo_in = seg_level[s];
            hi_in = seg_level[s+1];
            if (!found && lo_in <= x && x <= hi_in)
            begin
                found = 1'b1;
                if (hi_in != lo_in)
                begin
                    lo_out = seg_duty[s];
                    hi_out = seg_duty[s+1];
                    r.duty = DUTY_W'(lo_out + ((x - lo_in) * (hi_out - lo_out)) / (hi_in - lo_in));
                    r.err  = 1'b0;
                end
            end
        end
        return r;
    endfunction

    task automatic add_req(input int val, input bit known, input int d, input bit e);
        stim_row_t row;
        row.kind       = ROW_REQUEST;
        row.idx        = '0;
        row.data       = '0;
        row.req        = REQ_W'(val);
        row.known      = known;
        row.typed.duty = DUTY_W'(d);
        row.typed.err  = e;
        directed_q.push_back(row);
    endtask

    task automatic add_cfg(input int idx, input int data);
        stim_row_t row;
        row.kind  = ROW_WRITE;
        row.idx   = CFG_IDX_W'(idx);
        row.data  = CFG_DATA_W'(data);
        row.req   = '0;
        row.known = 1'b0;
        row.typed = '0;
        directed_q.push_back(row);
    endtask

    task automatic send_request(input logic signed [REQ_W-1:0] val, input bit known,
                                input dim_result_t typed);
        dim_result_t r;
        if (!steady && $urandom_range(0, 99) < GAP_PCT)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid        <= 1'b1;
        requested_level <= val;
        do @(posedge clk); while (!in_ready);
        if (!(last_seen && last_level == val))
        begin
            last_seen  = 1'b1;
            last_level = val;
            r = known ? typed : map_level(val);
            expected_duty_q.push_back(r);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx < REG_DUTY0)
            seg_level[idx - REG_LEVEL0] = data[LEVEL_W-1:0];
        else
            seg_duty[idx - REG_DUTY0] = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_duty_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        dim_result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready)
        begin
            if (expected_duty_q.size() == 0)
            begin
                mismatch_count++;
                $display("%0t unexpected result: duty_value %0d map_error %0d",
                         $time, duty_value, map_error);
            end
            else
            begin
                want = expected_duty_q.pop_front();
                if (duty_value !== want.duty)
                begin
                    mismatch_count++;
                    $display("%0t duty_value expected %0d actual %0d",
                             $time, want.duty, duty_value);
                end
                if (map_error !== want.err)
                begin
                    mismatch_count++;
                    $display("%0t map_error expected %0d actual %0d",
                             $time, want.err, map_error);
                end
            end
        end
        if (hold_epoch != hold_seen)
        begin
            hold_seen = hold_epoch;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= steady || ($urandom_range(0, 99) >= GAP_PCT);
    end

    initial
    begin
        for (i = 0; i < BREAKPOINTS; i++)
        begin
            seg_level[i] = LEVEL_RST[i];
            seg_duty[i]  = DUTY_RST[i];
        end

        add_req(0, 1, 0, 0);
        add_req(250, 1, 4000, 0);
        add_req(500, 1, 16000, 0);
        add_req(1000, 1, 65535, 0);
        add_req(1000, 0, 0, 0);
        add_req(-32768, 1, 0, 0);
        add_req(32767, 1, 65535, 0);
        add_req(32767, 0, 0, 0);
        add_req(-1, 1, 0, 0);
        add_req(1001, 1, 65535, 0);
        add_req(125, 0, 0, 0);
        add_req(375, 0, 0, 0);
        add_req(750, 0, 0, 0);
        add_cfg(REG_LEVEL0, 16'hFC64);
        add_req(50, 1, 0, 1);
        add_req(-5, 1, 0, 1);
        add_req(100, 1, 0, 0);
        add_cfg(REG_LEVEL0 + 1, 100);
        add_req(101, 0, 0, 0);
        add_req(100, 1, 0, 1);
        add_cfg(REG_DUTY0 + 1, 65535);
        add_cfg(REG_DUTY0 + 2, 0);
        add_req(300, 0, 0, 0);
        add_req(499, 0, 0, 0);
        add_cfg(REG_LEVEL0 + 2, 16'hFFFF);
        add_cfg(REG_LEVEL0 + 3, 16'h03FF);
        add_req(1000, 0, 0, 0);
        add_req(-32768, 1, 0, 1);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < directed_q.size(); k++)
        begin
            if (directed_q[k].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(directed_q[k].idx, directed_q[k].data);
            end
            else
                send_request(directed_q[k].req, directed_q[k].known, directed_q[k].typed);
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            a = $urandom_range(0, LEVEL_MAX);
            b = $urandom_range(0, LEVEL_MAX);
            if (a > b)
            begin
                i = a;
                a = b;
                b = i;
            end
            for (i = 0; i < BREAKPOINTS; i++)
                dt[i] = $urandom_range(0, 65535);
            case (phase)
                0:
                begin
                    for (i = 0; i < BREAKPOINTS; i++)
                    begin
                        lv[i] = LEVEL_RST[i];
                        dt[i] = DUTY_RST[i];
                    end
                end
                2, 9:
                begin
                    for (i = 0; i < BREAKPOINTS; i++)
                        lv[i] = $urandom_range(0, 1023);
                end
                3:
                begin
                    for (i = 0; i < BREAKPOINTS; i++)
                        lv[i] = 0;
                end
                4:
                begin
                    for (i = 0; i < BREAKPOINTS; i++)
                    begin
                        lv[i] = 1023;
                        dt[i] = 65535;
                    end
                end
                6:
                begin
                    lv = '{0, 0, LEVEL_MAX, LEVEL_MAX};
                    dt = '{65535, 0, 65535, 0};
                end
                7:
                begin
                    lv = '{0, a, b, LEVEL_MAX};
                    dt = '{0, 65535, 0, 65535};
                end
                default:
                    lv = '{0, a, b, LEVEL_MAX};
            endcase

            wait_idle();
            for (i = 0; i < BREAKPOINTS; i++)
                write_reg(REG_LEVEL0 + i,
                          CFG_DATA_W'(($urandom_range(0, 63) << LEVEL_W) | lv[i]));
            for (i = 0; i < BREAKPOINTS; i++)
                write_reg(REG_DUTY0 + i, CFG_DATA_W'(dt[i]));

            steady = (phase == 2);
            if (phase == 5)
                hold_epoch++;

            produced = 0;
            while (produced < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    v = last_level;
                else if (pick < 22)
                    v = REQ_W'(seg_level[$urandom_range(0, BREAKPOINTS - 1)]);
                else if (pick < 70)
                    v = REQ_W'($urandom_range(0, LEVEL_MAX));
                else if (pick < 75)
                    v = REQ_W'($urandom_range(LEVEL_MAX + 1, LEVEL_MAX + 30));
                else if (pick < 80)
                    v = REQ_W'(-int'($urandom_range(1, 30)));
                else
                    v = REQ_W'($urandom);
                if (!(last_seen && last_level == v))
                    produced++;
                send_request(v, 1'b0, '0);
                if (phase == 7 && produced == PHASE_ITEMS / 2)
                    wait_idle();
            end
        end

        steady = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_duty_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("piecewise_linear_dimming_map_core: match");
        else
            $display("piecewise_linear_dimming_map_core: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("piecewise_linear_dimming_map_core: mismatch");
        $finish;
    end

endmodule

>>> files.f
design/pldm_pkg.sv
design/pldm_cfg.sv
design/pldm_div.sv
design/piecewise_linear_dimming_map_core.sv
design/pldm_chk.sv
tb/tb.sv
